// ----- hdl/qslp_pkg.sv -----
// Shared constants and stage types for the quaternion slerp pipeline.
package qslp_pkg;

   localparam int CW         = 16;             // component width
   localparam int FB         = 14;             // fraction bits
   localparam int ONE        = 1 << FB;
   localparam int ANG        = 30;             // angle and trig fraction bits
   localparam int CORD_W     = 33;             // CORDIC datapath width
   localparam int CORD_STEPS = 30;
   localparam int SQ1_STEPS  = 31;             // sine-of-theta square root
   localparam int RAD1_W     = 2 * SQ1_STEPS;
   localparam int SQ1_REM_W  = 34;
   localparam int SQ2_STEPS  = CW;             // norm square root
   localparam int WDIV_STEPS = 31;             // weight quotient bits
   localparam int NDIV_STEPS = CW - 1;         // normalized quotient bits
   localparam int DOT_W      = 2 * CW;
   localparam int PROD_W     = 2 * CW + CW;    // weight times component
   localparam int SAT_HI     = (1 << (CW - 1)) - 1;
   localparam int SAT_LO     = -(1 << (CW - 1));

   localparam logic signed [CORD_W-1:0] CORD_GAIN_INV = 33'sd652032874;

   localparam logic [29:0] ATAN_TAB [0:CORD_STEPS-1] = '{
      30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
      30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
      30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
      30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
      30'd1024,      30'd512,       30'd256,       30'd128,       30'd64,
      30'd32,        30'd16,        30'd8,         30'd4,         30'd2
   };

   // item fields that ride along the front half
   typedef struct packed {
      logic [3:0][CW-1:0] a;
      logic [3:0][CW-1:0] b;
      logic [CW-1:0]      t;
      logic               want_unit;
      logic               clamp_lo;
      logic               clamp_hi;
      logic               neg;
      logic               lin;
      logic [FB:0]        x;
   } side_type;

   typedef struct packed {
      logic signed [CORD_W-1:0] x;
      logic signed [CORD_W-1:0] y;
      logic signed [CORD_W-1:0] z;
   } cord_type;

   typedef struct packed {
      side_type            side;
      logic [3:0][DOT_W-1:0] prod;
   } dotp_type;

   typedef struct packed {
      side_type               side;
      logic [RAD1_W-1:0]      rad;
      logic [SQ1_REM_W-1:0]   rem;
      logic [SQ1_STEPS-1:0]   root;
   } sq1_type;

   typedef struct packed {
      side_type             side;
      logic [SQ1_STEPS-1:0] s30;
      cord_type             c;
   } atan_type;

   typedef struct packed {
      side_type                   side;
      logic [SQ1_STEPS-1:0]       s30;
      logic signed [CORD_W-1:0]   theta;
      logic signed [CW+CORD_W-1:0] prod;
   } angm_type;

   typedef struct packed {
      side_type             side;
      logic [SQ1_STEPS-1:0] s30;
      cord_type             ca;
      cord_type             cb;
   } sin_type;

   typedef struct packed {
      side_type                        side;
      logic [SQ1_STEPS-1:0]            s30;
      logic [1:0]                      ovf;
      logic [1:0]                      sgn;
      logic [1:0][WDIV_STEPS-1:0]      rem;
      logic [1:0][WDIV_STEPS-1:0]      low;
      logic [1:0][WDIV_STEPS-1:0]      quo;
   } wdiv_type;

   typedef struct packed {
      side_type        side;
      logic [1:0][31:0] w;
   } wfin_type;

   typedef struct packed {
      side_type              side;
      logic [3:0][PROD_W-1:0] pa;
      logic [3:0][PROD_W-1:0] pb;
   } bmul_type;

   typedef struct packed {
      logic [3:0][CW-1:0] v;
      logic               norm_en;
   } vec_type;

   typedef struct packed {
      logic [3:0][CW-1:0]   v;
      logic                 norm_en;
      logic [3:0][2*CW-3:0] sq;
   } sqs_type;

   typedef struct packed {
      logic [3:0][CW-1:0] v;
      logic               norm_en;
      logic [2*CW-1:0]    rad;
      logic [CW+1:0]      rem;
      logic [CW-1:0]      root;
   } sq2_type;

   typedef struct packed {
      logic [3:0][CW-1:0]         v;
      logic                       norm_en;
      logic [CW-1:0]              nrm;
      logic [3:0]                 ovf;
      logic [3:0][CW-1:0]         rem;
      logic [3:0][NDIV_STEPS-1:0] low;
      logic [3:0][NDIV_STEPS-1:0] quo;
   } ndiv_type;

   typedef struct packed {
      logic [3:0][CW-1:0] q;
      logic               zero_norm;
   } out_type;

endpackage

// ----- hdl/quaternion_slerp.sv -----
// Quaternion slerp: fully pipelined fixed-point datapath from dot product to normalize.
// Throughput: one beat per cycle while not stalled; the chain of bit-per-stage square
//    roots, CORDIC rotations and restoring dividers is one register stage per step.
// Stalls freeze the whole pipe while the output register holds an untaken beat.
// Reset clears all valid bits and sets linear_threshold to 16383.
module quaternion_slerp (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [143:0]              req_tdata,  // a_x a_y a_z a_w b_x b_y b_z b_w blend
   input  logic                      req_tuser,  // want_unit
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [63:0]               rsp_tdata,  // q_x q_y q_z q_w
   output logic                      rsp_tuser,  // zero_norm
   input  logic                      csr_wr_en,
   input  logic [14:0]               csr_wr_data // linear_threshold
);
   import qslp_pkg::*;

   logic        pipe_adv;
   logic [14:0] thr_ff;

   side_type a_ff, a_in;
   logic     a_vld_ff;
   dotp_type b_ff, b_in;
   logic     b_vld_ff;
   side_type c_ff, c_in;
   logic     c_vld_ff;

   sq1_type  sq1_ff [0:SQ1_STEPS];
   logic     sq1_vld_ff [0:SQ1_STEPS];
   sq1_type  d_in;
   atan_type at_ff [0:CORD_STEPS];
   logic     at_vld_ff [0:CORD_STEPS];
   atan_type at0_in;
   angm_type m1_ff, m1_in;
   logic     m1_vld_ff;
   sin_type  sn_ff [0:CORD_STEPS];
   logic     sn_vld_ff [0:CORD_STEPS];
   sin_type  sn0_in;
   wdiv_type wd_ff [0:WDIV_STEPS];
   logic     wd_vld_ff [0:WDIV_STEPS];
   wdiv_type wd0_in;
   wfin_type wf_ff, wf_in;
   logic     wf_vld_ff;
   bmul_type bm_ff, bm_in;
   logic     bm_vld_ff;
   vec_type  bs_ff, bs_in;
   logic     bs_vld_ff;
   sqs_type  sqs_ff, sqs_in;
   logic     sqs_vld_ff;
   sq2_type  sq2_ff [0:SQ2_STEPS];
   logic     sq2_vld_ff [0:SQ2_STEPS];
   sq2_type  sq20_in;
   ndiv_type nd_ff [0:NDIV_STEPS];
   logic     nd_vld_ff [0:NDIV_STEPS];
   ndiv_type nd0_in;
   out_type  out_ff, out_in;
   logic     out_vld_ff;

   // global advance: the pipe moves unless the output beat is stuck
   assign pipe_adv   = !out_vld_ff || rsp_tready;
   assign req_tready = pipe_adv;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_ff.q[3], out_ff.q[2], out_ff.q[1], out_ff.q[0]};
   assign rsp_tuser  = out_ff.zero_norm;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 15'd16383;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // stage A: capture beat, classify blend
   always_comb begin
      a_in = '0;
      for (int i = 0; i < 4; i++) begin
         a_in.a[i] = req_tdata[i*CW +: CW];
         a_in.b[i] = req_tdata[(i+4)*CW +: CW];
      end
      a_in.t         = req_tdata[8*CW +: CW];
      a_in.want_unit = req_tuser;
      a_in.clamp_lo  = a_in.t[CW-1];
      a_in.clamp_hi  = $signed(a_in.t) > $signed(CW'(ONE));
   end

   // stage B: component products
   always_comb begin
      b_in.side = a_ff;
      for (int i = 0; i < 4; i++) begin
         b_in.prod[i] = DOT_W'($signed(a_ff.a[i]) * $signed(a_ff.b[i]));
      end
   end

   // stage C: dot product, hemisphere, linear select, clamp to one
   logic signed [DOT_W-1:0] dot_sum, dot_val;
   logic        [DOT_W-1:0] dot_abs;
   always_comb begin
      dot_sum = '0;
      for (int i = 0; i < 4; i++) begin
         dot_sum = dot_sum + ($signed(b_ff.prod[i]) >>> 2);
      end
      dot_val = dot_sum >>> (FB - 2);
      c_in     = b_ff.side;
      c_in.neg = dot_val[DOT_W-1];
      dot_abs  = c_in.neg ? DOT_W'(-dot_val) : DOT_W'(dot_val);
      c_in.lin = dot_abs > DOT_W'(thr_ff);
      c_in.x   = (dot_abs > DOT_W'(ONE)) ? (FB+1)'(ONE) : dot_abs[FB:0];
   end

   // stage D: radicand 1 - x^2 scaled up to the angle format
   logic [2*FB+1:0] x_sq, one_m_sq;
   always_comb begin
      x_sq      = (2*FB+2)'(c_ff.x * c_ff.x);
      one_m_sq  = ((2*FB+2)'(1) << (2*FB)) - x_sq;
      d_in.side = c_ff;
      d_in.rad  = {one_m_sq, {(RAD1_W-2*FB-2){1'b0}}};
      d_in.rem  = '0;
      d_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff      <= 1'b0;
         b_vld_ff      <= 1'b0;
         c_vld_ff      <= 1'b0;
         sq1_vld_ff[0] <= 1'b0;
      end else if (pipe_adv) begin
         a_vld_ff      <= req_tvalid;
         b_vld_ff      <= a_vld_ff;
         c_vld_ff      <= b_vld_ff;
         sq1_vld_ff[0] <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         a_ff      <= a_in;
         b_ff      <= b_in;
         c_ff      <= c_in;
         sq1_ff[0] <= d_in;
      end
   end

   // square root of the radicand, one result bit per stage
   for (genvar k = 0; k < SQ1_STEPS; k++) begin : g_sq1
      sq1_type               sq1_in;
      logic [SQ1_REM_W+1:0]  trial, part;
      always_comb begin
         sq1_in = sq1_ff[k];
         part   = {sq1_ff[k].rem, sq1_ff[k].rad[RAD1_W-1 -: 2]};
         trial  = {3'b000, sq1_ff[k].root, 2'b01};
         sq1_in.rad = sq1_ff[k].rad << 2;
         if (part >= trial) begin
            sq1_in.rem  = SQ1_REM_W'(part - trial);
            sq1_in.root = {sq1_ff[k].root[SQ1_STEPS-2:0], 1'b1};
         end else begin
            sq1_in.rem  = part[SQ1_REM_W-1:0];
            sq1_in.root = {sq1_ff[k].root[SQ1_STEPS-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sq1_vld_ff[k+1] <= 1'b0;
         end else if (pipe_adv) begin
            sq1_vld_ff[k+1] <= sq1_vld_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (pipe_adv) begin
            sq1_ff[k+1] <= sq1_in;
         end
      end
   end

   // CORDIC vectoring entry: theta = atan2(s, x)
   always_comb begin
      at0_in.side = sq1_ff[SQ1_STEPS].side;
      at0_in.s30  = sq1_ff[SQ1_STEPS].root;
      at0_in.c.x  = $signed(CORD_W'(sq1_ff[SQ1_STEPS].side.x) << (ANG - FB));
      at0_in.c.y  = $signed(CORD_W'(sq1_ff[SQ1_STEPS].root));
      at0_in.c.z  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_vld_ff[0] <= 1'b0;
      end else if (pipe_adv) begin
         at_vld_ff[0] <= sq1_vld_ff[SQ1_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         at_ff[0] <= at0_in;
      end
   end

   for (genvar k = 0; k < CORD_STEPS; k++) begin : g_atan
      atan_type at_in;
      always_comb begin
         at_in = at_ff[k];
         if (at_ff[k].c.y > 0) begin
            at_in.c.x = at_ff[k].c.x + (at_ff[k].c.y >>> k);
            at_in.c.y = at_ff[k].c.y - (at_ff[k].c.x >>> k);
            at_in.c.z = at_ff[k].c.z + $signed(CORD_W'(ATAN_TAB[k]));
         end else begin
            at_in.c.x = at_ff[k].c.x - (at_ff[k].c.y >>> k);
            at_in.c.y = at_ff[k].c.y + (at_ff[k].c.x >>> k);
            at_in.c.z = at_ff[k].c.z - $signed(CORD_W'(ATAN_TAB[k]));
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            at_vld_ff[k+1] <= 1'b0;
         end else if (pipe_adv) begin
            at_vld_ff[k+1] <= at_vld_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (pipe_adv) begin
            at_ff[k+1] <= at_in;
         end
      end
   end

   // t * theta
   always_comb begin
      m1_in.side  = at_ff[CORD_STEPS].side;
      m1_in.s30   = at_ff[CORD_STEPS].s30;
      m1_in.theta = at_ff[CORD_STEPS].c.z;
      m1_in.prod  = $signed(at_ff[CORD_STEPS].side.t) * at_ff[CORD_STEPS].c.z;
   end

   // split angles and seed both rotations
   logic signed [CW+CORD_W-1:0] angb_full;
   always_comb begin
      angb_full   = m1_ff.prod >>> FB;
      sn0_in.side = m1_ff.side;
      sn0_in.s30  = m1_ff.s30;
      sn0_in.cb.x = CORD_GAIN_INV;
      sn0_in.cb.y = '0;
      sn0_in.cb.z = angb_full[CORD_W-1:0];
      sn0_in.ca.x = CORD_GAIN_INV;
      sn0_in.ca.y = '0;
      sn0_in.ca.z = m1_ff.theta - $signed(angb_full[CORD_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff    <= 1'b0;
         sn_vld_ff[0] <= 1'b0;
      end else if (pipe_adv) begin
         m1_vld_ff    <= at_vld_ff[CORD_STEPS];
         sn_vld_ff[0] <= m1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         m1_ff    <= m1_in;
         sn_ff[0] <= sn0_in;
      end
   end

   // CORDIC rotation, two lanes for the two weights
   for (genvar k = 0; k < CORD_STEPS; k++) begin : g_sin
      sin_type  sn_in;
      cord_type ra, rb;
      always_comb begin
         sn_in = sn_ff[k];
         ra    = sn_ff[k].ca;
         rb    = sn_ff[k].cb;
         if (!ra.z[CORD_W-1]) begin
            sn_in.ca.x = ra.x - (ra.y >>> k);
            sn_in.ca.y = ra.y + (ra.x >>> k);
            sn_in.ca.z = ra.z - $signed(CORD_W'(ATAN_TAB[k]));
         end else begin
            sn_in.ca.x = ra.x + (ra.y >>> k);
            sn_in.ca.y = ra.y - (ra.x >>> k);
            sn_in.ca.z = ra.z + $signed(CORD_W'(ATAN_TAB[k]));
         end
         if (!rb.z[CORD_W-1]) begin
            sn_in.cb.x = rb.x - (rb.y >>> k);
            sn_in.cb.y = rb.y + (rb.x >>> k);
            sn_in.cb.z = rb.z - $signed(CORD_W'(ATAN_TAB[k]));
         end else begin
            sn_in.cb.x = rb.x + (rb.y >>> k);
            sn_in.cb.y = rb.y - (rb.x >>> k);
            sn_in.cb.z = rb.z + $signed(CORD_W'(ATAN_TAB[k]));
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sn_vld_ff[k+1] <= 1'b0;
         end else if (pipe_adv) begin
            sn_vld_ff[k+1] <= sn_vld_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (pipe_adv) begin
            sn_ff[k+1] <= sn_in;
         end
      end
   end

   // divider setup: |sin| * 2^F / s, overflow means clamp
   logic [1:0][CORD_W-1:0] sin_val;
   logic      [CORD_W-1:0] sin_mag;
   always_comb begin
      sin_val[0]  = sn_ff[CORD_STEPS].ca.y;
      sin_val[1]  = sn_ff[CORD_STEPS].cb.y;
      wd0_in      = '0;
      wd0_in.side = sn_ff[CORD_STEPS].side;
      wd0_in.s30  = sn_ff[CORD_STEPS].s30;
      for (int j = 0; j < 2; j++) begin
         sin_mag        = sin_val[j][CORD_W-1] ? CORD_W'(-$signed(sin_val[j])) : sin_val[j];
         wd0_in.sgn[j]  = sin_val[j][CORD_W-1];
         wd0_in.ovf[j]  = WDIV_STEPS'(sin_mag[CORD_W-1:WDIV_STEPS-FB]) >= sn_ff[CORD_STEPS].s30;
         wd0_in.rem[j]  = WDIV_STEPS'(sin_mag[CORD_W-1:WDIV_STEPS-FB]);
         wd0_in.low[j]  = {sin_mag[WDIV_STEPS-FB-1:0], {FB{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wd_vld_ff[0] <= 1'b0;
      end else if (pipe_adv) begin
         wd_vld_ff[0] <= sn_vld_ff[CORD_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         wd_ff[0] <= wd0_in;
      end
   end

   // restoring division, one quotient bit per stage, both weights
   for (genvar k = 0; k < WDIV_STEPS; k++) begin : g_wdiv
      wdiv_type        wd_in;
      logic [WDIV_STEPS:0] part;
      always_comb begin
         wd_in = wd_ff[k];
         for (int j = 0; j < 2; j++) begin
            part          = {wd_ff[k].rem[j], wd_ff[k].low[j][WDIV_STEPS-1]};
            wd_in.low[j]  = wd_ff[k].low[j] << 1;
            if (part >= {1'b0, wd_ff[k].s30}) begin
               wd_in.rem[j] = WDIV_STEPS'(part - {1'b0, wd_ff[k].s30});
               wd_in.quo[j] = {wd_ff[k].quo[j][WDIV_STEPS-2:0], 1'b1};
            end else begin
               wd_in.rem[j] = part[WDIV_STEPS-1:0];
               wd_in.quo[j] = {wd_ff[k].quo[j][WDIV_STEPS-2:0], 1'b0};
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            wd_vld_ff[k+1] <= 1'b0;
         end else if (pipe_adv) begin
            wd_vld_ff[k+1] <= wd_vld_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (pipe_adv) begin
            wd_ff[k+1] <= wd_in;
         end
      end
   end

   // final weights: clamp, sign, linear fallback, hemisphere flip
   wdiv_type           wd_last;
   logic [WDIV_STEPS-1:0] w_mag;
   logic [31:0]        t_ext;
   always_comb begin
      wd_last    = wd_ff[WDIV_STEPS];
      wf_in.side = wd_last.side;
      t_ext      = {{(32-CW){wd_last.side.t[CW-1]}}, wd_last.side.t};
      for (int j = 0; j < 2; j++) begin
         w_mag       = wd_last.ovf[j] ? '1 : wd_last.quo[j];
         wf_in.w[j]  = wd_last.sgn[j] ? 32'(-$signed({1'b0, w_mag})) : {1'b0, w_mag};
      end
      if (wd_last.side.lin || (wd_last.s30 == '0)) begin
         wf_in.w[0] = 32'(ONE) - t_ext;
         wf_in.w[1] = t_ext;
      end
      if (wd_last.side.neg) begin
         wf_in.w[1] = 32'(-$signed(wf_in.w[1]));
      end
   end

   // weight times component
   always_comb begin
      bm_in.side = wf_ff.side;
      for (int i = 0; i < 4; i++) begin
         bm_in.pa[i] = PROD_W'($signed(wf_ff.w[0]) * $signed(wf_ff.side.a[i]));
         bm_in.pb[i] = PROD_W'($signed(wf_ff.w[1]) * $signed(wf_ff.side.b[i]));
      end
   end

   // blend sum, rescale, saturate; clamped t picks a or b
   logic signed [PROD_W:0] bl_sum, bl_sh;
   always_comb begin
      bs_in.norm_en = bm_ff.side.clamp_lo || bm_ff.side.clamp_hi || bm_ff.side.want_unit;
      for (int i = 0; i < 4; i++) begin
         bl_sum = (PROD_W+1)'($signed(bm_ff.pa[i])) + (PROD_W+1)'($signed(bm_ff.pb[i]));
         bl_sh  = bl_sum >>> FB;
         if (bl_sh > $signed((PROD_W+1)'(SAT_HI))) begin
            bs_in.v[i] = CW'(SAT_HI);
         end else if (bl_sh < $signed((PROD_W+1)'(SAT_LO))) begin
            bs_in.v[i] = CW'(SAT_LO);
         end else begin
            bs_in.v[i] = bl_sh[CW-1:0];
         end
         if (bm_ff.side.clamp_lo) begin
            bs_in.v[i] = bm_ff.side.a[i];
         end else if (bm_ff.side.clamp_hi) begin
            bs_in.v[i] = bm_ff.side.b[i];
         end
      end
   end

   // squares with magnitude capped at the positive limit
   logic [CW-2:0] sq_mag;
   always_comb begin
      sqs_in.v       = bs_ff.v;
      sqs_in.norm_en = bs_ff.norm_en;
      for (int i = 0; i < 4; i++) begin
         if (bs_ff.v[i] == CW'(SAT_LO)) begin
            sq_mag = (CW-1)'(SAT_HI);
         end else if (bs_ff.v[i][CW-1]) begin
            sq_mag = (CW-1)'(-$signed(bs_ff.v[i]));
         end else begin
            sq_mag = bs_ff.v[i][CW-2:0];
         end
         sqs_in.sq[i] = (2*CW-2)'(sq_mag * sq_mag);
      end
   end

   // sum of squares into the norm square root
   always_comb begin
      sq20_in.v       = sqs_ff.v;
      sq20_in.norm_en = sqs_ff.norm_en;
      sq20_in.rad     = (2*CW)'(sqs_ff.sq[0]) + (2*CW)'(sqs_ff.sq[1])
                      + (2*CW)'(sqs_ff.sq[2]) + (2*CW)'(sqs_ff.sq[3]);
      sq20_in.rem     = '0;
      sq20_in.root    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wf_vld_ff     <= 1'b0;
         bm_vld_ff     <= 1'b0;
         bs_vld_ff     <= 1'b0;
         sqs_vld_ff    <= 1'b0;
         sq2_vld_ff[0] <= 1'b0;
      end else if (pipe_adv) begin
         wf_vld_ff     <= wd_vld_ff[WDIV_STEPS];
         bm_vld_ff     <= wf_vld_ff;
         bs_vld_ff     <= bm_vld_ff;
         sqs_vld_ff    <= bs_vld_ff;
         sq2_vld_ff[0] <= sqs_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         wf_ff     <= wf_in;
         bm_ff     <= bm_in;
         bs_ff     <= bs_in;
         sqs_ff    <= sqs_in;
         sq2_ff[0] <= sq20_in;
      end
   end

   // norm square root, one bit per stage
   for (genvar k = 0; k < SQ2_STEPS; k++) begin : g_sq2
      sq2_type       sq2_in;
      logic [CW+3:0] trial, part;
      always_comb begin
         sq2_in = sq2_ff[k];
         part   = {sq2_ff[k].rem, sq2_ff[k].rad[2*CW-1 -: 2]};
         trial  = {2'b00, sq2_ff[k].root, 2'b01};
         sq2_in.rad = sq2_ff[k].rad << 2;
         if (part >= trial) begin
            sq2_in.rem  = (CW+2)'(part - trial);
            sq2_in.root = {sq2_ff[k].root[CW-2:0], 1'b1};
         end else begin
            sq2_in.rem  = part[CW+1:0];
            sq2_in.root = {sq2_ff[k].root[CW-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sq2_vld_ff[k+1] <= 1'b0;
         end else if (pipe_adv) begin
            sq2_vld_ff[k+1] <= sq2_vld_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (pipe_adv) begin
            sq2_ff[k+1] <= sq2_in;
         end
      end
   end

   // normalize divider setup: |v| * 2^F / norm
   logic [CW-1:0] v_mag;
   always_comb begin
      nd0_in         = '0;
      nd0_in.v       = sq2_ff[SQ2_STEPS].v;
      nd0_in.norm_en = sq2_ff[SQ2_STEPS].norm_en;
      nd0_in.nrm     = sq2_ff[SQ2_STEPS].root;
      for (int i = 0; i < 4; i++) begin
         v_mag = sq2_ff[SQ2_STEPS].v[i][CW-1] ? CW'(-$signed(sq2_ff[SQ2_STEPS].v[i]))
                                              : sq2_ff[SQ2_STEPS].v[i];
         nd0_in.ovf[i] = CW'(v_mag[CW-1:NDIV_STEPS-FB]) >= sq2_ff[SQ2_STEPS].root;
         nd0_in.rem[i] = CW'(v_mag[CW-1:NDIV_STEPS-FB]);
         nd0_in.low[i] = {v_mag[NDIV_STEPS-FB-1:0], {FB{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nd_vld_ff[0] <= 1'b0;
      end else if (pipe_adv) begin
         nd_vld_ff[0] <= sq2_vld_ff[SQ2_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         nd_ff[0] <= nd0_in;
      end
   end

   // restoring division for the four components
   for (genvar k = 0; k < NDIV_STEPS; k++) begin : g_ndiv
      ndiv_type  nd_in;
      logic [CW:0] part;
      always_comb begin
         nd_in = nd_ff[k];
         for (int i = 0; i < 4; i++) begin
            part         = {nd_ff[k].rem[i], nd_ff[k].low[i][NDIV_STEPS-1]};
            nd_in.low[i] = nd_ff[k].low[i] << 1;
            if (part >= {1'b0, nd_ff[k].nrm}) begin
               nd_in.rem[i] = CW'(part - {1'b0, nd_ff[k].nrm});
               nd_in.quo[i] = {nd_ff[k].quo[i][NDIV_STEPS-2:0], 1'b1};
            end else begin
               nd_in.rem[i] = part[CW-1:0];
               nd_in.quo[i] = {nd_ff[k].quo[i][NDIV_STEPS-2:0], 1'b0};
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            nd_vld_ff[k+1] <= 1'b0;
         end else if (pipe_adv) begin
            nd_vld_ff[k+1] <= nd_vld_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (pipe_adv) begin
            nd_ff[k+1] <= nd_in;
         end
      end
   end

   // output: raw blend, normalized (saturated on overflow), or zeros with zero-norm flag
   ndiv_type nd_last;
   always_comb begin
      nd_last = nd_ff[NDIV_STEPS];
      out_in.zero_norm = nd_last.norm_en && (nd_last.nrm == '0);
      for (int i = 0; i < 4; i++) begin
         if (!nd_last.norm_en) begin
            out_in.q[i] = nd_last.v[i];
         end else if (out_in.zero_norm) begin
            out_in.q[i] = '0;
         end else if (nd_last.ovf[i]) begin
            out_in.q[i] = nd_last.v[i][CW-1] ? CW'(SAT_LO) : CW'(SAT_HI);
         end else if (nd_last.v[i][CW-1]) begin
            out_in.q[i] = CW'(-$signed({1'b0, nd_last.quo[i]}));
         end else begin
            out_in.q[i] = {1'b0, nd_last.quo[i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (pipe_adv) begin
         out_vld_ff <= nd_vld_ff[NDIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         out_ff <= out_in;
      end
   end

endmodule
